// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define ASSERT_SAME(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("assertion failed: same-cycle implication");

// Check that a condition holds in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/itda_pkg.sv =====
// Package: shared types, constants and digit helper for the decimal text converter.
`timescale 1ns / 1ps
package itda_pkg;

  typedef logic [7:0] char_t;
  typedef logic [3:0] digit_t;

  localparam int DEFAULT_VALUE_BITS = 32;
  localparam int DEFAULT_DIGITS     = ((DEFAULT_VALUE_BITS - 1) * 301) / 1000 + 1;
  localparam int STEPS_PER_STAGE    = 8;

  localparam char_t CHAR_ZERO  = 8'd48;
  localparam char_t CHAR_MINUS = 8'd45;

  function automatic digit_t dabble_adj(digit_t d);
    return (d >= 4'd5) ? digit_t'(d + 4'd3) : d;
  endfunction

endpackage

// ===== rtl/itda_dabble.sv =====
// One pipeline stage of the shift-and-add-3 binary to BCD conversion.
`timescale 1ns / 1ps
module itda_dabble #(
  parameter int VALUE_BITS = itda_pkg::DEFAULT_VALUE_BITS,
  parameter int NDIG       = itda_pkg::DEFAULT_DIGITS,
  parameter int STEPS      = itda_pkg::STEPS_PER_STAGE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_neg,
  input  logic [4*NDIG-1:0]     in_bcd,
  input  logic [VALUE_BITS-1:0] in_mag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_neg,
  output logic [4*NDIG-1:0]     out_bcd,
  output logic [VALUE_BITS-1:0] out_mag
);
  import itda_pkg::*;

  localparam int BW = 4 * NDIG;

  logic [BW+VALUE_BITS-1:0] acc;

  always_comb begin
    acc = {in_bcd, in_mag};
    for (int s = 0; s < STEPS; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        acc[VALUE_BITS+4*d +: 4] = dabble_adj(acc[VALUE_BITS+4*d +: 4]);
      end
      acc = acc << 1;
    end
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_neg <= in_neg;
      out_bcd <= acc[VALUE_BITS +: BW];
      out_mag <= acc[VALUE_BITS-1:0];
    end
  end

endmodule

// ===== rtl/itda_serial.sv =====
// Output serializer: sends the minus sign, if any, and the digits of one item as single characters.
`timescale 1ns / 1ps
module itda_serial #(
  parameter int NDIG = itda_pkg::DEFAULT_DIGITS,
  parameter int IW   = $clog2(NDIG)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_neg,
  input  logic [NDIG-1:0][3:0]   in_bcd,
  input  logic [IW-1:0]          in_top,
  output logic                   char_valid,
  input  logic                   char_ready,
  output itda_pkg::char_t        character,
  output logic                   last_char
);
  import itda_pkg::*;

  logic                 free;
  logic                 rem_busy;
  logic [IW-1:0]        rem_idx;
  logic [NDIG-1:0][3:0] rem_bcd;

  assign free     = ~char_valid | char_ready;
  assign in_ready = free & ~rem_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      rem_busy   <= 1'b0;
    end else if (free) begin
      if (rem_busy) begin
        char_valid <= 1'b1;
        character  <= char_t'(CHAR_ZERO + {4'b0, rem_bcd[rem_idx]});
        last_char  <= (rem_idx == '0);
        rem_busy   <= (rem_idx != '0);
        rem_idx    <= rem_idx - 1'b1;
      end else if (in_valid) begin
        char_valid <= 1'b1;
        rem_bcd    <= in_bcd;
        if (in_neg) begin
          character <= CHAR_MINUS;
          last_char <= 1'b0;
          rem_busy  <= 1'b1;
          rem_idx   <= in_top;
        end else begin
          character <= char_t'(CHAR_ZERO + {4'b0, in_bcd[in_top]});
          last_char <= (in_top == '0);
          rem_busy  <= (in_top != '0);
          rem_idx   <= in_top - 1'b1;
        end
      end else begin
        char_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/int_to_decimal_ascii_top.sv =====
// Path: input register, then NST = ceil(VALUE_BITS / 8) dabble stages, load register and character register.
// Throughput: one character per cycle while char_ready is high; an item gives one character per
// digit plus one for a minus sign (1 to 11 characters at 32 bits), via the single-character output register.
// The conversion pipeline takes a new item every cycle while the output keeps up.
// Reset: synchronous; clears stage valid bits and the serializer busy flag, data is not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module int_to_decimal_ascii_top #(
  parameter int VALUE_BITS = itda_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         value_valid,
  output logic                         value_ready,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         char_valid,
  input  logic                         char_ready,
  output itda_pkg::char_t              character,
  output logic                         last_char
);
  import itda_pkg::*;

  localparam int NDIG = ((VALUE_BITS - 1) * 301) / 1000 + 1;
  localparam int BW   = 4 * NDIG;
  localparam int NST  = (VALUE_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int IW   = $clog2(NDIG);

  logic                  s0_valid;
  logic                  s0_neg;
  logic [VALUE_BITS-1:0] s0_mag;

  logic [NST:0]                 st_valid;
  logic [NST:0]                 st_ready;
  logic [NST:0]                 st_neg;
  logic [NST:0][BW-1:0]         st_bcd;
  logic [NST:0][VALUE_BITS-1:0] st_mag;

  logic                 ld_valid;
  logic                 ld_ready;
  logic                 ld_neg;
  logic [NDIG-1:0][3:0] ld_bcd;
  logic [IW-1:0]        ld_top;
  logic [IW-1:0]        top_next;
  logic                 ld_take;
  logic                 char_ok;

  assign value_ready = ~s0_valid | st_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (value_ready) begin
      s0_valid <= value_valid;
    end
    if (value_valid && value_ready) begin
      s0_neg <= value[VALUE_BITS-1];
      s0_mag <= value[VALUE_BITS-1] ? ($unsigned(~value) + 1'b1) : $unsigned(value);
    end
  end

  assign st_valid[0] = s0_valid;
  assign st_neg[0]   = s0_neg;
  assign st_bcd[0]   = '0;
  assign st_mag[0]   = s0_mag;

  for (genvar k = 0; k < NST; k++) begin : g_stage
    localparam int LEFT  = VALUE_BITS - k * STEPS_PER_STAGE;
    localparam int STEPS = (LEFT < STEPS_PER_STAGE) ? LEFT : STEPS_PER_STAGE;
    itda_dabble #(
      .VALUE_BITS(VALUE_BITS),
      .NDIG      (NDIG),
      .STEPS     (STEPS)
    ) u_dabble (
      .clk      (clk),
      .rst      (rst),
      .in_valid (st_valid[k]),
      .in_ready (st_ready[k]),
      .in_neg   (st_neg[k]),
      .in_bcd   (st_bcd[k]),
      .in_mag   (st_mag[k]),
      .out_valid(st_valid[k+1]),
      .out_ready(st_ready[k+1]),
      .out_neg  (st_neg[k+1]),
      .out_bcd  (st_bcd[k+1]),
      .out_mag  (st_mag[k+1])
    );
  end

  always_comb begin
    top_next = '0;
    for (int d = 1; d < NDIG; d++) begin
      if (st_bcd[NST][4*d +: 4] != 4'd0) begin
        top_next = IW'(d);
      end
    end
  end

  assign st_ready[NST] = ~ld_valid | ld_ready;
  assign ld_take       = ld_valid & ld_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ld_valid <= 1'b0;
    end else if (st_ready[NST]) begin
      ld_valid <= st_valid[NST];
    end
    if (st_valid[NST] && st_ready[NST]) begin
      ld_neg <= st_neg[NST];
      ld_bcd <= st_bcd[NST];
      ld_top <= top_next;
    end
  end

  itda_serial #(
    .NDIG(NDIG),
    .IW  (IW)
  ) u_serial (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ld_valid),
    .in_ready  (ld_ready),
    .in_neg    (ld_neg),
    .in_bcd    (ld_bcd),
    .in_top    (ld_top),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .character (character),
    .last_char (last_char)
  );

  assign char_ok = (character == CHAR_MINUS) ||
                   ((character >= CHAR_ZERO) && (character <= 8'd57));

  `ASSERT_SAME(a_char_code, clk, rst, char_valid, char_ok)
  `ASSERT_SAME(a_minus_not_last, clk, rst, char_valid && (character == CHAR_MINUS), !last_char)
  `ASSERT_NEXT(a_take_shows_char, clk, rst, ld_take, char_valid)
  `ASSERT_SAME(a_stall_only_full, clk, rst, !value_ready, s0_valid)

endmodule
